[design/lbpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_pkg
// Shared types, constants and helpers for the laser blanking path generator.
// ----------------------------------------------------------------------------
package lbpg_pkg;

  // coordinate and run widths
  localparam int COORD_BITS   = 16;
  localparam int RUN_BITS     = 7;
  localparam int LANES        = 3;
  localparam int LANE_BITS    = 2;
  localparam int DIV_STEPS    = COORD_BITS;
  localparam int DIV_CNT_BITS = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [RUN_BITS-1:0]          count_t;
  typedef logic [1:0]                   reg_idx_t;

  localparam count_t MAX_RUN = 7'd64;

  // register map
  localparam reg_idx_t REG_START_COUNT = 2'd0;
  localparam reg_idx_t REG_START_HOLD  = 2'd1;
  localparam reg_idx_t REG_END_COUNT   = 2'd2;

  localparam count_t RST_START_COUNT = 7'd8;
  localparam count_t RST_START_HOLD  = 7'd3;
  localparam count_t RST_END_COUNT   = 7'd8;

  // run types
  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_HOLD,
    S_RUN
  } seq_state_t;

  typedef struct packed {
    count_t start_count;
    count_t start_hold_count;
    count_t end_count;
  } cfg_t;

  typedef struct packed {
    logic   start;
    mag_t   dividend;
    count_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    mag_t   quot;
    count_t rem;
  } div_rsp_t;

  // clamp a run length to the longest supported run
  function automatic count_t sat_count(count_t c);
    return (c > MAX_RUN) ? MAX_RUN : c;
  endfunction

endpackage

[design/lbpg_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_cfg_regs
// APB register bank holding the start, hold and end run lengths.
// ----------------------------------------------------------------------------
module lbpg_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lbpg_pkg::cfg_t    cfg
);
  import lbpg_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_count      <= RST_START_COUNT;
      cfg.start_hold_count <= RST_START_HOLD;
      cfg.end_count        <= RST_END_COUNT;
    end else if (wr_en) begin
      case (idx)
        REG_START_COUNT: cfg.start_count      <= pwdata[RUN_BITS-1:0];
        REG_START_HOLD:  cfg.start_hold_count <= pwdata[RUN_BITS-1:0];
        REG_END_COUNT:   cfg.end_count        <= pwdata[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_START_COUNT: prdata = 32'(cfg.start_count);
      REG_START_HOLD:  prdata = 32'(cfg.start_hold_count);
      REG_END_COUNT:   prdata = 32'(cfg.end_count);
      default:         prdata = '0;
    endcase
  end

endmodule

[design/lbpg_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_divider
// Restoring divider, one quotient bit per cycle, shared by all three axes.
// ----------------------------------------------------------------------------
module lbpg_divider (
  input  logic                clk,
  input  logic                rst,
  input  lbpg_pkg::div_req_t  req,
  output lbpg_pkg::div_rsp_t  rsp
);
  import lbpg_pkg::*;

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  count_t                  rem;
  count_t                  dvs;
  mag_t                    quot;
  logic [RUN_BITS:0]       trial;
  logic                    fits;
  count_t                  rem_next;
  mag_t                    quot_next;

  // one restoring step
  always_comb begin
    trial     = {rem, quot[COORD_BITS-1]};
    fits      = trial >= {1'b0, dvs};
    rem_next  = fits ? RUN_BITS'(trial - {1'b0, dvs}) : trial[RUN_BITS-1:0];
    quot_next = {quot[COORD_BITS-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quot <= req.dividend;
      dvs  <= req.divisor;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

[design/lbpg_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_seq
// Run sequencer: builds the anchor, drives the shared divider once per axis,
// then steps a quotient/remainder accumulator, one point per out_free cycle.
// ----------------------------------------------------------------------------
module lbpg_seq (
  input  logic                clk,
  input  logic                rst,
  input  lbpg_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  lbpg_pkg::coord_t    poly [lbpg_pkg::LANES],
  input  lbpg_pkg::coord_t    nb   [lbpg_pkg::LANES],
  input  logic                has_neighbour,
  output logic                out_valid,
  input  logic                out_stall,
  output lbpg_pkg::coord_t    out_x,
  output lbpg_pkg::coord_t    out_y,
  output lbpg_pkg::coord_t    out_z,
  output logic                run_last,
  output lbpg_pkg::div_req_t  div_req,
  input  lbpg_pkg::div_rsp_t  div_rsp
);
  import lbpg_pkg::*;

  seq_state_t           state;
  seq_state_t           state_next;
  logic [LANE_BITS-1:0] lane;
  count_t               hold_left;
  count_t               run_m;
  count_t               k;
  coord_t               lane_a [LANES];
  coord_t               lane_b [LANES];
  logic                 neg    [LANES];
  mag_t                 step_q [LANES];
  count_t               step_r [LANES];
  mag_t                 acc_q  [LANES];
  count_t               acc_r  [LANES];

  count_t               n_sel;
  count_t               hold_sel;
  count_t               m_sel;
  logic [COORD_BITS:0]  mid_sum [LANES];
  coord_t               anc     [LANES];
  coord_t               a_sel   [LANES];
  coord_t               b_sel   [LANES];
  logic [COORD_BITS:0]  diff;
  logic                 diff_neg;
  mag_t                 diff_mag;
  logic [RUN_BITS:0]    r_sum   [LANES];
  logic                 r_wrap  [LANES];
  coord_t               pt      [LANES];
  logic                 pt_last;
  logic                 accept;
  logic                 emit;
  logic                 out_free;

  // run setup from the incoming item
  always_comb begin
    n_sel = sat_count((opcode == OP_END) ? cfg.end_count : cfg.start_count);
    if (opcode == OP_END) begin
      hold_sel = '0;
    end else begin
      hold_sel = (cfg.start_hold_count < n_sel) ? cfg.start_hold_count : n_sel;
    end
    m_sel = n_sel - hold_sel;
    for (int j = 0; j < LANES; j++) begin
      mid_sum[j] = {poly[j][COORD_BITS-1], poly[j]} + {nb[j][COORD_BITS-1], nb[j]};
      anc[j]     = has_neighbour ? coord_t'(mid_sum[j][COORD_BITS:1]) : poly[j];
      a_sel[j]   = (opcode == OP_END) ? poly[j] : anc[j];
      b_sel[j]   = (opcode == OP_END) ? anc[j]  : poly[j];
    end
  end

  // magnitude and sign of the span for the axis being divided
  always_comb begin
    diff     = {lane_b[lane][COORD_BITS-1], lane_b[lane]}
             - {lane_a[lane][COORD_BITS-1], lane_a[lane]};
    diff_neg = diff[COORD_BITS];
    diff_mag = diff_neg ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
  end

  // point values and accumulator carries
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      r_sum[j]  = {1'b0, acc_r[j]} + {1'b0, step_r[j]};
      r_wrap[j] = r_sum[j] >= {1'b0, run_m};
      if (state == S_HOLD) begin
        pt[j] = lane_a[j];
      end else begin
        pt[j] = lane_a[j] + (neg[j] ? coord_t'(-acc_q[j]) : coord_t'(acc_q[j]));
      end
    end
    if (state == S_HOLD) begin
      pt_last = (hold_left == 7'd1) && (run_m == '0);
    end else begin
      pt_last = (k == run_m - 1'b1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (n_sel == '0) begin
            state_next = S_IDLE;
          end else if (m_sel != '0) begin
            state_next = S_DIV_GO;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_DIV_GO: begin
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (lane == LANE_BITS'(LANES - 1)) begin
            state_next = (hold_left != '0) ? S_HOLD : S_RUN;
          end else begin
            state_next = S_DIV_GO;
          end
        end
      end
      S_HOLD: begin
        if (emit && (hold_left == 7'd1)) begin
          state_next = (run_m != '0) ? S_RUN : S_IDLE;
        end
      end
      S_RUN: begin
        if (emit && pt_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall         = (state != S_IDLE);
    accept           = (state == S_IDLE) && in_valid;
    out_free         = !out_valid || !out_stall;
    emit             = ((state == S_HOLD) || (state == S_RUN)) && out_free;
    div_req.start    = (state == S_DIV_GO);
    div_req.dividend = diff_mag;
    div_req.divisor  = run_m;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // run datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_left <= hold_sel;
      run_m     <= m_sel;
      k         <= '0;
      lane      <= '0;
      for (int j = 0; j < LANES; j++) begin
        lane_a[j] <= a_sel[j];
        lane_b[j] <= b_sel[j];
        acc_q[j]  <= '0;
        acc_r[j]  <= '0;
      end
    end
    if (state == S_DIV_GO) begin
      neg[lane] <= diff_neg;
    end
    if ((state == S_DIV_WAIT) && div_rsp.done) begin
      step_q[lane] <= div_rsp.quot;
      step_r[lane] <= div_rsp.rem;
      lane         <= lane + 1'b1;
    end
    if ((state == S_HOLD) && emit) begin
      hold_left <= hold_left - 1'b1;
    end
    if ((state == S_RUN) && emit) begin
      k <= k + 1'b1;
      for (int j = 0; j < LANES; j++) begin
        if (r_wrap[j]) begin
          acc_r[j] <= RUN_BITS'(r_sum[j] - {1'b0, run_m});
          acc_q[j] <= acc_q[j] + step_q[j] + 1'b1;
        end else begin
          acc_r[j] <= r_sum[j][RUN_BITS-1:0];
          acc_q[j] <= acc_q[j] + step_q[j];
        end
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x    <= pt[0];
      out_y    <= pt[1];
      out_z    <= pt[2];
      run_last <= pt_last;
    end
  end

endmodule

[design/laser_blanking_path_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_blanking_path_generator
// Emits blanked laser points leading into or out of a polyline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one run request: opcode picks a
//   start or end run, poly_* is the polyline point, neighbour_* with
//   has_neighbour gives the point the anchor is the floor midpoint with.
//   Output channel (out_valid/out_stall) carries one point per transfer,
//   run_last marks the final point of a run; a zero-length run gives none.
//   Run lengths live in the APB registers start_count (0x0),
//   start_hold_count (0x4) and end_count (0x8); lengths clamp at 64.
// Timing:
//   A run that moves off the anchor first divides each axis span by its count
//   of moving points in the shared 16-step divider, one axis after another,
//   then emits one point per cycle unless the output stalls; a run of held
//   points only skips the divider. in_stall is high for the whole run.
//   A receiver stall freezes the output register and the point stepping.
// Reset:
//   rst is synchronous; it empties the output and restores the run lengths
//   to 8, 3 and 8.
// ----------------------------------------------------------------------------
module laser_blanking_path_generator (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  lbpg_pkg::coord_t      poly_x,
  input  lbpg_pkg::coord_t      poly_y,
  input  lbpg_pkg::coord_t      poly_z,
  input  lbpg_pkg::coord_t      neighbour_x,
  input  lbpg_pkg::coord_t      neighbour_y,
  input  lbpg_pkg::coord_t      neighbour_z,
  input  logic                  has_neighbour,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lbpg_pkg::coord_t      out_x,
  output lbpg_pkg::coord_t      out_y,
  output lbpg_pkg::coord_t      out_z,
  output logic                  run_last
);
  import lbpg_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  coord_t   poly_v [LANES];
  coord_t   nb_v   [LANES];

  // gather axes into lanes
  assign poly_v[0] = poly_x;
  assign poly_v[1] = poly_y;
  assign poly_v[2] = poly_z;
  assign nb_v[0]   = neighbour_x;
  assign nb_v[1]   = neighbour_y;
  assign nb_v[2]   = neighbour_z;

  lbpg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lbpg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lbpg_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .poly          (poly_v),
    .nb            (nb_v),
    .has_neighbour (has_neighbour),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .run_last      (run_last),
    .div_req       (div_req),
    .div_rsp       (div_rsp)
  );

endmodule
